// ----- src/mmlc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmlc_pkg
// Shared types and codes for the multi-mode light controller.
// ----------------------------------------------------------------------------
package mmlc_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned ValueW  = 11;
  localparam int unsigned MinuteW = 11;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned DataW   = 16;

  // control modes
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_SENSOR  = 3'd1;
  localparam logic [2:0] MODE_CLOCK   = 3'd2;
  localparam logic [2:0] MODE_TURNOUT = 3'd3;
  localparam logic [2:0] MODE_TIMED   = 3'd4;
  localparam logic [2:0] MODE_TWO     = 3'd5;

  // event kinds
  localparam logic [KindW-1:0] KIND_SENSOR1  = 3'd0;
  localparam logic [KindW-1:0] KIND_SENSOR2  = 3'd1;
  localparam logic [KindW-1:0] KIND_TURNOUT  = 3'd2;
  localparam logic [KindW-1:0] KIND_MINUTE   = 3'd3;
  localparam logic [KindW-1:0] KIND_TICK     = 3'd4;
  localparam logic [KindW-1:0] KIND_ACTIVATE = 3'd5;

  // state codes
  localparam logic [CodeW-1:0] CODE_UNKNOWN      = 2'd0;
  localparam logic [CodeW-1:0] CODE_ACTIVE       = 2'd1;
  localparam logic [CodeW-1:0] CODE_INACTIVE     = 2'd2;
  localparam logic [CodeW-1:0] CODE_INCONSISTENT = 2'd3;

  // state codes at event value width
  localparam logic [ValueW-1:0] VALUE_UNKNOWN      = {{(ValueW-CodeW){1'b0}}, CODE_UNKNOWN};
  localparam logic [ValueW-1:0] VALUE_ACTIVE       = {{(ValueW-CodeW){1'b0}}, CODE_ACTIVE};
  localparam logic [ValueW-1:0] VALUE_INACTIVE     = {{(ValueW-CodeW){1'b0}}, CODE_INACTIVE};
  localparam logic [ValueW-1:0] VALUE_INCONSISTENT = {{(ValueW-CodeW){1'b0}},
                                                      CODE_INCONSISTENT};

  // register indexes
  localparam logic [IndexW-1:0] REG_CONTROL_MODE   = 3'd0;
  localparam logic [IndexW-1:0] REG_SENSE_ACTIVE   = 3'd1;
  localparam logic [IndexW-1:0] REG_ON_WHEN_CLOSED = 3'd2;
  localparam logic [IndexW-1:0] REG_ON_MINUTE      = 3'd3;
  localparam logic [IndexW-1:0] REG_OFF_MINUTE     = 3'd4;
  localparam logic [IndexW-1:0] REG_ON_DURATION    = 3'd5;
  localparam logic [IndexW-1:0] REG_LIGHT_ENABLED  = 3'd6;

  typedef struct packed {
    logic [2:0]         control_mode;
    logic               sense_active;
    logic               on_when_closed;
    logic [MinuteW-1:0] on_minute;
    logic [MinuteW-1:0] off_minute;
    logic [TicksW-1:0]  on_duration;
    logic               light_enabled;
  } cfg_t;

  typedef struct packed {
    logic               light_state;
    logic [CodeW-1:0]   first_sensor;
    logic [CodeW-1:0]   second_sensor;
    logic [TicksW-1:0]  countdown;
    logic               countdown_busy;
  } state_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] event_value;
  } item_t;

  typedef struct packed {
    logic light_on;
    logic command_issued;
    logic schedule_fault;
    logic timer_running;
  } result_t;

endpackage

// ----- src/mmlc_cfg.sv -----
// ----------------------------------------------------------------------------
// mmlc_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module mmlc_cfg
  import mmlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IndexW-1:0] wr_index,
  input  logic [DataW-1:0]  wr_data,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode   <= MODE_NONE;
      cfg.sense_active   <= 1'b1;
      cfg.on_when_closed <= 1'b1;
      cfg.on_minute      <= '0;
      cfg.off_minute     <= '0;
      cfg.on_duration    <= '0;
      cfg.light_enabled  <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CONTROL_MODE:   cfg.control_mode   <= wr_data[2:0];
        REG_SENSE_ACTIVE:   cfg.sense_active   <= wr_data[0];
        REG_ON_WHEN_CLOSED: cfg.on_when_closed <= wr_data[0];
        REG_ON_MINUTE:      cfg.on_minute      <= wr_data[MinuteW-1:0];
        REG_OFF_MINUTE:     cfg.off_minute     <= wr_data[MinuteW-1:0];
        REG_ON_DURATION:    cfg.on_duration    <= wr_data[TicksW-1:0];
        REG_LIGHT_ENABLED:  cfg.light_enabled  <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/mmlc_eval.sv -----
// ----------------------------------------------------------------------------
// mmlc_eval
// Next-state and result logic for one event item.
// ----------------------------------------------------------------------------
module mmlc_eval
  import mmlc_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic             do_drive;
  logic             drive_val;
  logic [CodeW-1:0] sens;
  logic [CodeW-1:0] want;
  logic             win;
  logic             en;

  always_comb begin
    st_next   = st;
    do_drive  = 1'b0;
    drive_val = 1'b0;
    en        = cfg.light_enabled;
    sens      = (item.event_value > VALUE_INCONSISTENT) ? CODE_INCONSISTENT
                                                        : item.event_value[CodeW-1:0];
    want      = cfg.sense_active ? CODE_ACTIVE : CODE_INACTIVE;
    if (cfg.on_minute <= cfg.off_minute) begin
      win = (item.event_value >= cfg.on_minute) && (item.event_value < cfg.off_minute);
    end else begin
      win = (item.event_value >= cfg.on_minute) || (item.event_value < cfg.off_minute);
    end

    case (item.kind)
      KIND_SENSOR1: begin
        st_next.first_sensor = sens;
        if (en && cfg.control_mode == MODE_SENSOR) begin
          do_drive  = (sens == CODE_ACTIVE) || (sens == CODE_INACTIVE);
          drive_val = (sens == CODE_ACTIVE) ? cfg.sense_active : ~cfg.sense_active;
        end else if (en && cfg.control_mode == MODE_TWO) begin
          do_drive  = 1'b1;
          drive_val = (sens == want) || (st.second_sensor == want);
        end else if (en && cfg.control_mode == MODE_TIMED) begin
          if (sens == CODE_ACTIVE && !st.countdown_busy) begin
            do_drive               = 1'b1;
            drive_val              = 1'b1;
            st_next.countdown      = cfg.on_duration;
            st_next.countdown_busy = 1'b1;
          end
        end
      end
      KIND_SENSOR2: begin
        st_next.second_sensor = sens;
        if (en && cfg.control_mode == MODE_TWO) begin
          do_drive  = 1'b1;
          drive_val = (st.first_sensor == want) || (sens == want);
        end
      end
      KIND_TURNOUT: begin
        if (en && cfg.control_mode == MODE_TURNOUT) begin
          do_drive  = (item.event_value == VALUE_ACTIVE) ||
                      (item.event_value == VALUE_INACTIVE);
          drive_val = (item.event_value == VALUE_ACTIVE) ? cfg.on_when_closed
                                                         : ~cfg.on_when_closed;
        end
      end
      KIND_MINUTE: begin
        if (en && cfg.control_mode == MODE_CLOCK) begin
          do_drive  = (win != st.light_state);
          drive_val = win;
        end
      end
      KIND_TICK: begin
        if (st.countdown_busy) begin
          if (st.countdown <= 16'd1) begin
            st_next.countdown      = '0;
            st_next.countdown_busy = 1'b0;
            do_drive               = 1'b1;
            drive_val              = 1'b0;
          end else begin
            st_next.countdown = st.countdown - 16'd1;
          end
        end
      end
      KIND_ACTIVATE: begin
        if (en) begin
          case (cfg.control_mode)
            MODE_SENSOR: begin
              do_drive  = (st.first_sensor == CODE_ACTIVE) ||
                          (st.first_sensor == CODE_INACTIVE);
              drive_val = (st.first_sensor == CODE_ACTIVE) ? cfg.sense_active
                                                           : ~cfg.sense_active;
            end
            MODE_CLOCK: begin
              do_drive  = (win != st.light_state);
              drive_val = win;
            end
            MODE_TURNOUT: begin
              do_drive  = (item.event_value == VALUE_ACTIVE) ||
                          (item.event_value == VALUE_INACTIVE);
              drive_val = (item.event_value == VALUE_ACTIVE) ? cfg.on_when_closed
                                                             : ~cfg.on_when_closed;
            end
            MODE_TIMED: begin
              do_drive  = 1'b1;
              drive_val = 1'b0;
            end
            MODE_TWO: begin
              do_drive  = 1'b1;
              drive_val = (st.first_sensor == want) || (st.second_sensor == want);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    if (do_drive) begin
      st_next.light_state = drive_val;
    end

    res.light_on       = st_next.light_state;
    res.command_issued = do_drive;
    res.schedule_fault = (cfg.on_minute == cfg.off_minute);
    res.timer_running  = st_next.countdown_busy;
  end

endmodule

// ----- src/multi_mode_light_controller.sv -----
// ----------------------------------------------------------------------------
// multi_mode_light_controller
// One light driven by sensor, turnout, clock window or one-shot timer events.
//
//   channel  dir  handshake              payload
//   s_axis   in   tvalid / tready        tuser kind, tdata event_value
//   m_axis   out  tvalid / tready        tdata result flags
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while m_axis_tready is high
// the input register feeds a single evaluation stage into the result register
// reset clears mode, state and both valid flags; config is always ready
// with m_axis_tready low the result holds and one more item is taken in
// ----------------------------------------------------------------------------
module multi_mode_light_controller
  import mmlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // event_value[10:0], zero fill
  input  logic [KindW-1:0]  s_axis_tuser,  // kind[2:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // light_on, command_issued,
                                           // schedule_fault, timer_running, zero fill
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IndexW-1:0] cfg_index,
  input  logic [DataW-1:0]  cfg_data
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   in_item;
  logic    in_valid;
  result_t res_next;
  result_t res;
  logic    advance;

  assign cfg_ready = 1'b1;

  mmlc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mmlc_eval u_eval (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (res_next)
  );

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      st            <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        st            <= st_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.kind        <= s_axis_tuser;
      in_item.event_value <= s_axis_tdata[ValueW-1:0];
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {4'b0000, res.timer_running, res.schedule_fault,
                         res.command_issued, res.light_on};

`ifndef SYNTHESIS
  a_idle_countdown_zero: assert property (@(posedge clk) disable iff (rst)
    !st.countdown_busy |-> st.countdown == '0)
    else $error("countdown left non-zero while idle");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == st.light_state) &&
                      (m_axis_tdata[3] == st.countdown_busy))
    else $error("pending result disagrees with light state");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: multi_mode_light_controller
// Sends layout events and register writes to the light controller. A local
// model of the light, the stored sensors and the one-shot countdown predicts
// each result flag, which is checked against the result stream. A short
// directed pass covers each mode and its corner cases. Randomised phases
// follow, each with fresh settings; the first eleven add random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mmlc_pkg::*;

  localparam int unsigned QuietLimit = 1000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata = '0;  // event_value[10:0], zero fill
  logic [KindW-1:0]   s_axis_tuser = '0;  // kind[2:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;       // light_on, command_issued,
                                          // schedule_fault, timer_running, zero fill
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IndexW-1:0]  cfg_index = '0;
  logic [DataW-1:0]   cfg_data = '0;

  // register copy
  logic [2:0]         mode = MODE_NONE;
  bit                 sense_on = 1'b1;
  bit                 closed_on = 1'b1;
  logic [MinuteW-1:0] on_min = '0;
  logic [MinuteW-1:0] off_min = '0;
  logic [TicksW-1:0]  duration = '0;
  bit                 enabled = 1'b1;

  // light state copy
  bit                 lamp = 1'b0;
  logic [CodeW-1:0]   first_code = CODE_UNKNOWN;
  logic [CodeW-1:0]   second_code = CODE_UNKNOWN;
  logic [TicksW-1:0]  ticks_left = '0;
  bit                 timer_busy = 1'b0;
  bit                 issued;

  result_t            light_reports[$];

  int unsigned        mismatches = 0;
  int unsigned        events_sent = 0;
  int unsigned        reports_seen = 0;
  int unsigned        reg_writes = 0;
  int unsigned        gap_pct = 20;
  int unsigned        stall_pct = 20;
  int unsigned        stall_left = 0;
  int unsigned        quiet_cycles = 0;
  bit                 calm = 1'b0;

  always #5 clk = ~clk;

  multi_mode_light_controller uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic void light_set(input bit on);
    lamp = on;
    issued = 1'b1;
  endfunction

  function automatic void follow_code(input logic [CodeW-1:0] code, input bit on_match);
    if (code == CODE_ACTIVE) begin
      light_set(on_match);
    end else if (code == CODE_INACTIVE) begin
      light_set(!on_match);
    end
  endfunction

  function automatic void follow_pair();
    logic [CodeW-1:0] want;
    want = sense_on ? CODE_ACTIVE : CODE_INACTIVE;
    light_set(first_code == want || second_code == want);
  endfunction

  function automatic void follow_window(input logic [ValueW-1:0] now);
    bit on;
    if (on_min <= off_min) begin
      on = (now >= on_min) && (now < off_min);
    end else begin
      on = (now >= on_min) || (now < off_min);
    end
    if (on != lamp) light_set(on);
  endfunction

  task automatic predict_light(input logic [KindW-1:0] k, input logic [ValueW-1:0] v);
    result_t          r;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] position;
    code = (v > VALUE_INCONSISTENT) ? CODE_INCONSISTENT : v[1:0];
    position = (v > VALUE_INCONSISTENT) ? CODE_UNKNOWN : v[1:0];
    issued = 1'b0;
    case (k)
      KIND_SENSOR1: begin
        first_code = code;
        if (enabled) begin
          if (mode == MODE_SENSOR) begin
            follow_code(first_code, sense_on);
          end else if (mode == MODE_TWO) begin
            follow_pair();
          end else if (mode == MODE_TIMED && first_code == CODE_ACTIVE && !timer_busy) begin
            light_set(1'b1);
            ticks_left = duration;
            timer_busy = 1'b1;
          end
        end
      end
      KIND_SENSOR2: begin
        second_code = code;
        if (enabled && mode == MODE_TWO) follow_pair();
      end
      KIND_TURNOUT: begin
        if (enabled && mode == MODE_TURNOUT) follow_code(position, closed_on);
      end
      KIND_MINUTE: begin
        if (enabled && mode == MODE_CLOCK) follow_window(v);
      end
      KIND_TICK: begin
        if (timer_busy) begin
          if (ticks_left <= 16'd1) begin
            ticks_left = '0;
            timer_busy = 1'b0;
            light_set(1'b0);
          end else begin
            ticks_left = ticks_left - 16'd1;
          end
        end
      end
      KIND_ACTIVATE: begin
        if (enabled) begin
          case (mode)
            MODE_SENSOR:  follow_code(first_code, sense_on);
            MODE_CLOCK:   follow_window(v);
            MODE_TURNOUT: follow_code(position, closed_on);
            MODE_TIMED:   light_set(1'b0);
            MODE_TWO:     follow_pair();
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    r.light_on = lamp;
    r.command_issued = issued;
    r.schedule_fault = (on_min == off_min);
    r.timer_running = timer_busy;
    light_reports.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_flag(input string what, input bit got, input bit want);
    if (got !== want) report_mismatch(what, int'(got), int'(want));
  endtask

  // receiver side, with stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.light_on = m_axis_tdata[0];
      got.command_issued = m_axis_tdata[1];
      got.schedule_fault = m_axis_tdata[2];
      got.timer_running = m_axis_tdata[3];
      reports_seen++;
      if (light_reports.size() == 0) begin
        report_mismatch("result with nothing pending, light_on", int'(got.light_on), 0);
      end else begin
        want = light_reports.pop_front();
        check_flag("light_on", got.light_on, want.light_on);
        check_flag("command_issued", got.command_issued, want.command_issued);
        check_flag("schedule_fault", got.schedule_fault, want.schedule_fault);
        check_flag("timer_running", got.timer_running, want.timer_running);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", QuietLimit);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic [KindW-1:0] k, input logic [ValueW-1:0] v);
    cfg_valid <= 1'b0;
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= 16'(v);
    do @(posedge clk); while (!s_axis_tready);
    events_sent++;
    predict_light(k, v);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (light_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] index, input logic [DataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (index)
      REG_CONTROL_MODE:   mode = value[2:0];
      REG_SENSE_ACTIVE:   sense_on = value[0];
      REG_ON_WHEN_CLOSED: closed_on = value[0];
      REG_ON_MINUTE:      on_min = value[MinuteW-1:0];
      REG_OFF_MINUTE:     off_min = value[MinuteW-1:0];
      REG_ON_DURATION:    duration = value[TicksW-1:0];
      REG_LIGHT_ENABLED:  enabled = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [2:0] m, input bit sense, input bit closed,
                           input logic [MinuteW-1:0] a, input logic [MinuteW-1:0] b,
                           input logic [TicksW-1:0] ticks, input bit en);
    drain();
    write_reg(REG_CONTROL_MODE, 16'(m));
    write_reg(REG_SENSE_ACTIVE, 16'(sense));
    write_reg(REG_ON_WHEN_CLOSED, 16'(closed));
    write_reg(REG_ON_MINUTE, 16'(a));
    write_reg(REG_OFF_MINUTE, 16'(b));
    write_reg(REG_ON_DURATION, ticks);
    write_reg(REG_LIGHT_ENABLED, 16'(en));
  endtask

  task automatic test_sensor_follow();
    configure(MODE_SENSOR, 1'b1, 1'b1, 11'd0, 11'd0, 16'd0, 1'b1);
    send_event(KIND_SENSOR1, VALUE_ACTIVE);
    send_event(KIND_SENSOR1, VALUE_INACTIVE);
    send_event(KIND_SENSOR1, VALUE_UNKNOWN);
    send_event(KIND_SENSOR1, 11'h7FF);
    send_event(KIND_ACTIVATE, 11'd0);
    configure(MODE_SENSOR, 1'b0, 1'b1, 11'd0, 11'd0, 16'd0, 1'b1);
    send_event(KIND_SENSOR1, VALUE_ACTIVE);
    send_event(KIND_ACTIVATE, 11'd0);
  endtask

  task automatic test_two_sensor();
    configure(MODE_TWO, 1'b1, 1'b1, 11'd0, 11'd0, 16'd0, 1'b1);
    send_event(KIND_SENSOR2, VALUE_ACTIVE);
    send_event(KIND_SENSOR1, VALUE_INACTIVE);
    send_event(KIND_SENSOR2, VALUE_INCONSISTENT);
    send_event(KIND_ACTIVATE, 11'd0);
  endtask

  task automatic test_turnout();
    configure(MODE_TURNOUT, 1'b1, 1'b1, 11'd0, 11'd0, 16'd0, 1'b1);
    send_event(KIND_TURNOUT, VALUE_ACTIVE);
    send_event(KIND_TURNOUT, VALUE_INACTIVE);
    send_event(KIND_TURNOUT, VALUE_UNKNOWN);
    configure(MODE_TURNOUT, 1'b1, 1'b0, 11'd0, 11'd0, 16'd0, 1'b1);
    send_event(KIND_ACTIVATE, VALUE_ACTIVE);
  endtask

  task automatic test_clock_window();
    // window wrapping past midnight
    configure(MODE_CLOCK, 1'b1, 1'b1, 11'd1439, 11'd0, 16'd0, 1'b1);
    send_event(KIND_MINUTE, 11'd1439);
    send_event(KIND_MINUTE, 11'd0);
    send_event(KIND_ACTIVATE, 11'h7FF);
    configure(MODE_CLOCK, 1'b1, 1'b1, 11'd60, 11'd120, 16'd0, 1'b1);
    send_event(KIND_MINUTE, 11'd60);
    send_event(KIND_MINUTE, 11'd119);
    send_event(KIND_MINUTE, 11'd120);
    // empty window
    configure(MODE_CLOCK, 1'b1, 1'b1, 11'd100, 11'd100, 16'd0, 1'b1);
    send_event(KIND_MINUTE, 11'd100);
  endtask

  task automatic test_one_shot();
    configure(MODE_TIMED, 1'b1, 1'b1, 11'd0, 11'd1439, 16'd0, 1'b1);
    send_event(KIND_SENSOR1, VALUE_ACTIVE);
    send_event(KIND_SENSOR1, VALUE_ACTIVE);
    send_event(KIND_TICK, 11'd0);
    send_event(KIND_SENSOR1, VALUE_ACTIVE);
    send_event(KIND_ACTIVATE, 11'd0);
    send_event(KIND_TICK, 11'd0);
  endtask

  task automatic test_disabled();
    configure(MODE_TIMED, 1'b1, 1'b1, 11'd0, 11'd0, 16'd2, 1'b1);
    send_event(KIND_SENSOR1, VALUE_ACTIVE);
    configure(MODE_TIMED, 1'b1, 1'b1, 11'd0, 11'd0, 16'd2, 1'b0);
    send_event(KIND_SENSOR1, VALUE_INACTIVE);
    send_event(KIND_TICK, 11'd0);
    send_event(KIND_TICK, 11'd0);
    send_event(3'd6, 11'h7FF);
    send_event(3'd7, 11'h555);
  endtask

  function automatic logic [MinuteW-1:0] pick_minute();
    case ($urandom_range(0, 3))
      0: return 11'd0;
      1: return 11'd1439;
      default: return 11'($urandom_range(0, 1439));
    endcase
  endfunction

  task automatic random_setup(input bit widest);
    int unsigned        pick;
    logic [2:0]         m;
    logic [MinuteW-1:0] a;
    logic [MinuteW-1:0] b;
    logic [TicksW-1:0]  ticks;
    bit                 en;
    pick = $urandom_range(0, 9);
    m = (pick > 7) ? 3'(pick - 4) : 3'(pick);
    a = pick_minute();
    b = ($urandom_range(0, 4) == 0) ? a : pick_minute();
    ticks = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 400))
                                        : 16'($urandom_range(0, 6));
    en = ($urandom_range(0, 6) != 0);
    if (widest) begin
      m = MODE_TIMED;
      ticks = 16'hFFFF;
      en = 1'b1;
    end
    configure(m, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), a, b, ticks, en);
  endtask

  task automatic random_event();
    int unsigned        r;
    logic [KindW-1:0]   k;
    logic [ValueW-1:0]  v;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      k = 3'($urandom_range(0, 7));
    end else if (r < 20) begin
      k = KIND_ACTIVATE;
    end else begin
      case (mode)
        MODE_SENSOR:  k = KIND_SENSOR1;
        MODE_TWO:     k = r[0] ? KIND_SENSOR1 : KIND_SENSOR2;
        MODE_TURNOUT: k = KIND_TURNOUT;
        MODE_CLOCK:   k = KIND_MINUTE;
        MODE_TIMED:   k = (r < 65) ? KIND_TICK : KIND_SENSOR1;
        default:      k = 3'($urandom_range(0, 7));
      endcase
    end
    if (k == KIND_MINUTE || (k == KIND_ACTIVATE && mode == MODE_CLOCK)) begin
      case ($urandom_range(0, 9))
        0: v = 11'($urandom_range(0, 2047));
        1: v = on_min;
        2: v = off_min;
        3: v = off_min - 11'd1;
        default: v = 11'($urandom_range(0, 1439));
      endcase
    end else if ($urandom_range(0, 6) == 0) begin
      v = 11'($urandom_range(0, 2047));
    end else begin
      v = 11'($urandom_range(0, 3));
    end
    send_event(k, v);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 14; phase++) begin
      gap_pct = 15 * $urandom_range(0, 2);
      stall_pct = 15 * $urandom_range(0, 2);
      // last phases run at full rate
      calm = (phase >= 11);
      random_setup(phase == 13);
      repeat (85) random_event();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_sensor_follow();
    test_two_sensor();
    test_turnout();
    test_clock_window();
    test_one_shot();
    test_disabled();
    test_random_phases();
    drain();
    repeat (8) @(posedge clk);
    $display("covered all six modes, unused modes and kinds, wrapped and empty clock windows,");
    $display("%0d events, %0d results compared, %0d register writes", events_sent,
             reports_seen, reg_writes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
